// ===== rtl/psrd_pkg.sv =====
package psrd_pkg;

    // payload widths shared by the channels and the decoder
    localparam int BYTE_BITS      = 8;
    localparam int SKIP_BITS      = 16;
    localparam int CFG_INDEX_BITS = 8;

    typedef logic [BYTE_BITS-1:0] t_byte;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STRIP_MODE   = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COLOR_ORDER  = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 8'd3;

    // scan modes
    localparam logic STRIP_LINES     = 1'b0;
    localparam logic STRIP_SERPENTINE = 1'b1;

    // color orders, the reserved code decodes as rgba
    localparam logic [1:0] ORDER_RGBA = 2'd0;
    localparam logic [1:0] ORDER_RGB  = 2'd1;
    localparam logic [1:0] ORDER_GRBA = 2'd2;

    localparam t_byte OPAQUE_ALPHA = 8'd255;

    // reset values of the frame size
    localparam t_byte FRAME_WIDTH_RST  = 8'd8;
    localparam t_byte FRAME_HEIGHT_RST = 8'd8;

    // inside the frame the position is below 255 * 255 and fits this many bits
    localparam int DIVIDEND_BITS = 16;

endpackage

// ===== rtl/psrd_channels.sv =====
// record input channel
interface psrd_in_if import psrd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 frame_start;
    logic [SKIP_BITS-1:0] skip_count;
    t_byte                byte_one;
    t_byte                byte_two;
    t_byte                byte_three;
    t_byte                byte_four;

    modport source (
        output valid, frame_start, skip_count, byte_one, byte_two, byte_three, byte_four,
        input  ready
    );
    modport sink (
        input  valid, frame_start, skip_count, byte_one, byte_two, byte_three, byte_four,
        output ready
    );
endinterface

// decoded pixel output channel
interface psrd_out_if import psrd_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte pixel_x;
    t_byte pixel_y;
    t_byte red;
    t_byte green;
    t_byte blue;
    t_byte alpha;
    logic  in_frame;

    modport source (
        output valid, pixel_x, pixel_y, red, green, blue, alpha, in_frame,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, red, green, blue, alpha, in_frame,
        output ready
    );
endinterface

// configuration write channel
interface psrd_cfg_if import psrd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    t_byte                     data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== rtl/pixel_strip_record_decoder_unit.sv =====
// Pixel strip record decoder. Each record on i_pix advances the strip position by its
// skip count (saturating at the top of the position range, cleared first when
// frame_start is set), and one decoded pixel leaves on o_pix with its (x,y), its color
// in red, green, blue, alpha order and an in-frame flag. The position is mapped line by
// line or as serpentine columns through one shared restoring divider that retires one
// quotient bit per cycle. A record inside the frame passes acceptance, the bounds check,
// 16 divide steps and the output load before the next record can be accepted; a record
// outside the frame skips the divide steps. The finished pixel waits in an output
// register, so the next record is taken while it is still unread. Configuration writes
// are accepted in every cycle and must only be made while the decoder is idle.
module pixel_strip_record_decoder_unit import psrd_pkg::*; #(
    parameter int POSITION_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    psrd_cfg_if.sink      i_cfg,
    psrd_in_if.sink       i_pix,
    psrd_out_if.source    o_pix
);

    localparam int PB       = POSITION_BITS;
    localparam int DB       = DIVIDEND_BITS;
    localparam int CNT_BITS = $clog2(DB);
    localparam int AREA_BITS = 2 * BYTE_BITS;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_DIVIDE = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    // configuration registers
    logic          r_strip_mode;
    logic [1:0]    r_color_order;
    t_byte         r_frame_width;
    t_byte         r_frame_height;
    logic [AREA_BITS-1:0] r_area;

    // control state
    logic [1:0]          r_state;
    logic [PB-1:0]       r_pos;
    logic [PB-1:0]       r_pos_work;
    logic                r_inside;
    logic [CNT_BITS-1:0] r_bit_cnt;
    logic                r_out_valid;

    // record payload and divider datapath
    t_byte         r_b1, r_b2, r_b3, r_b4;
    t_byte         r_div;
    t_byte         r_rem;
    logic [DB-1:0] r_quo;

    // output registers
    t_byte r_px, r_py, r_red, r_green, r_blue, r_alpha;
    logic  r_in_frame;

    logic [PB-1:0]        n_pos_base;
    logic [PB:0]          n_pos_sum;
    logic [PB-1:0]        n_pos_sat;
    logic [PB-1:0]        n_pos_inc;
    logic                 n_inside;
    logic [BYTE_BITS:0]   n_trial;
    logic [BYTE_BITS+1:0] n_diff;
    t_byte                n_rem;
    t_byte                n_px, n_py, n_red, n_green, n_blue, n_alpha;
    logic                 out_free;

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = (r_state == ST_IDLE);

    assign o_pix.valid    = r_out_valid;
    assign o_pix.pixel_x  = r_px;
    assign o_pix.pixel_y  = r_py;
    assign o_pix.red      = r_red;
    assign o_pix.green    = r_green;
    assign o_pix.blue     = r_blue;
    assign o_pix.alpha    = r_alpha;
    assign o_pix.in_frame = r_in_frame;

    assign out_free = !r_out_valid || o_pix.ready;

    // saturating advance by the skip count
    always_comb begin
        n_pos_base = i_pix.frame_start ? '0 : r_pos;
        n_pos_sum  = {1'b0, n_pos_base} + {{(PB + 1 - SKIP_BITS){1'b0}}, i_pix.skip_count};
        n_pos_sat  = n_pos_sum[PB] ? '1 : n_pos_sum[PB-1:0];
    end

    // saturating advance past the pixel and bounds check
    always_comb begin
        n_pos_inc = (&r_pos_work) ? r_pos_work : r_pos_work + {{(PB - 1){1'b0}}, 1'b1};
        n_inside  = (r_pos_work < {{(PB - AREA_BITS){1'b0}}, r_area});
    end

    // one restoring divide step
    always_comb begin
        n_trial = {r_rem, r_quo[DB-1]};
        n_diff  = {1'b0, n_trial} - {2'b00, r_div};
        n_rem   = n_diff[BYTE_BITS+1] ? n_trial[BYTE_BITS-1:0] : n_diff[BYTE_BITS-1:0];
    end

    // coordinates from quotient and remainder
    always_comb begin
        n_px = '0;
        n_py = '0;
        if (r_inside) begin
            if (r_strip_mode == STRIP_SERPENTINE) begin
                n_px = r_quo[BYTE_BITS-1:0];
                n_py = r_quo[0] ? (r_frame_height - 8'd1 - r_rem) : r_rem;
            end else begin
                n_px = r_rem;
                n_py = r_quo[BYTE_BITS-1:0];
            end
        end
    end

    // color byte order
    always_comb begin
        unique case (r_color_order)
            ORDER_RGB: begin
                n_red   = r_b1;
                n_green = r_b2;
                n_alpha = OPAQUE_ALPHA;
            end
            ORDER_GRBA: begin
                n_red   = r_b2;
                n_green = r_b1;
                n_alpha = r_b4;
            end
            default: begin
                n_red   = r_b1;
                n_green = r_b2;
                n_alpha = r_b4;
            end
        endcase
        n_blue = r_b3;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip_mode   <= STRIP_LINES;
            r_color_order  <= ORDER_RGBA;
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_STRIP_MODE:   r_strip_mode   <= i_cfg.data[0];
                CFG_COLOR_ORDER:  r_color_order  <= i_cfg.data[1:0];
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // frame area, zero when either dimension is zero
    always_ff @(posedge i_clk) begin
        r_area <= r_frame_width * r_frame_height;
    end

    // record sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_bit_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a pixel item leaves; a load in ST_EMIT sets the flag again instead
            if (r_out_valid && o_pix.ready && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_pix.valid) begin
                        r_pos_work <= n_pos_sat;
                        r_b1       <= i_pix.byte_one;
                        r_b2       <= i_pix.byte_two;
                        r_b3       <= i_pix.byte_three;
                        r_b4       <= i_pix.byte_four;
                        r_state    <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    r_pos     <= n_pos_inc;
                    r_inside  <= n_inside;
                    r_quo     <= r_pos_work[DB-1:0];
                    r_rem     <= '0;
                    r_div     <= (r_strip_mode == STRIP_SERPENTINE) ? r_frame_height
                                                                    : r_frame_width;
                    r_bit_cnt <= '0;
                    r_state   <= n_inside ? ST_DIVIDE : ST_EMIT;
                end
                ST_DIVIDE: begin
                    r_rem     <= n_rem;
                    r_quo     <= {r_quo[DB-2:0], ~n_diff[BYTE_BITS+1]};
                    r_bit_cnt <= r_bit_cnt + {{(CNT_BITS - 1){1'b0}}, 1'b1};
                    if (&r_bit_cnt) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_px        <= n_px;
                        r_py        <= n_py;
                        r_red       <= n_red;
                        r_green     <= n_green;
                        r_blue      <= n_blue;
                        r_alpha     <= n_alpha;
                        r_in_frame  <= r_inside;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
